// ----- design/cuae_pkg.sv -----
// ----------------------------------------------------------------------------
// cuae_pkg: shared types and constants for the upload engine
// Item structs, command and status codes, and the queue record between the
// front (receive and decode) and back (transfer and emission) parts.
// ----------------------------------------------------------------------------
package cuae_pkg;

  localparam logic [1:0] OP_NOTIFY = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_LINK   = 2'd2;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [3:0] ST_DONE     = 4'd0;
  localparam logic [3:0] ST_REJECTED = 4'd1;
  localparam logic [3:0] ST_CACHE    = 4'd2;
  localparam logic [3:0] ST_BIG      = 4'd3;
  localparam logic [3:0] ST_RETRIES  = 4'd4;
  localparam logic [3:0] ST_UNKNOWN  = 4'd5;
  localparam logic [3:0] ST_OVERFLOW = 4'd6;
  localparam logic [3:0] ST_BADLEN   = 4'd7;
  localparam logic [3:0] ST_SHORT    = 4'd8;

  localparam logic [7:0] CMD_HANDSHAKE = 8'd17;
  localparam logic [7:0] CMD_CHUNK     = 8'd18;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [10:0] fragment_length;
    logic        fragment_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  frame_byte;
    logic [31:0] payload_offset;
    logic [9:0]  payload_count;
    logic [3:0]  status_code;
    logic        run_end;
  } out_item_t;

  // Work handed from front to back.
  typedef enum logic [2:0] {
    JOB_START, JOB_CLEAR, JOB_STATUS, JOB_ACK_HS, JOB_ACK_CHUNK
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  status;
    logic [7:0]  ack_status;
    logic [15:0] cache;
  } job_t;

  function automatic logic [7:0] header_byte(input logic [3:0] idx, input logic [7:0] cmd,
                                             input logic [15:0] flen, input logic [7:0] seq);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0:  b = 8'hAA;
      4'd1:  b = cmd;
      4'd3:  b = 8'h5A;
      4'd4:  b = flen[7:0];
      4'd5:  b = flen[15:8];
      4'd6:  b = seq;
      4'd8:  b = 8'h54;
      4'd9:  b = 8'h46;
      4'd10: b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- design/cuae_front.sv -----
// ----------------------------------------------------------------------------
// cuae_front: fragment reassembly and frame classification
// Accepts items, gathers frame bytes, checks lengths and emits jobs.
// ----------------------------------------------------------------------------
module cuae_front #(
  parameter int RX_BUFFER_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cuae_pkg::in_item_t in_item,
  output logic              in_ready,
  output logic              job_valid,
  output cuae_pkg::job_t    job,
  input  logic              job_ready
);
  import cuae_pkg::*;

  localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

  logic [CW-1:0] rx_count;
  logic [16:0]   rx_expected;
  logic [7:0]    cap [6];
  logic          frag_dropping, frag_started;

  logic          take;
  logic          emit;
  job_t          job_next;
  logic [CW-1:0] cnt_next;
  logic [16:0]   exp_next;
  logic          drop_next, started_next;
  logic          drop_w;
  logic [CW-1:0] cnt_w;
  logic [7:0]    c_len_lo, c_len_hi;
  logic [7:0]    c_cache_hi;
  logic [16:0]   frame_len;
  logic [16:0]   e;
  logic [17:0]   sum;

  assign in_ready = !job_valid || job_ready;
  assign take = in_valid && in_ready;
  assign sum = 18'(rx_count) + 18'(in_item.fragment_length);

  always_comb begin
    emit = 1'b0;
    job_next = '0;
    job_next.kind = JOB_CLEAR;
    cnt_next = rx_count;
    exp_next = rx_expected;
    drop_next = frag_dropping;
    started_next = frag_started;
    drop_w = frag_dropping;
    cnt_w = rx_count;
    c_len_lo = cap[1];
    c_len_hi = cap[2];
    c_cache_hi = cap[5];
    frame_len = '0;
    e = '0;
    case (in_item.operation)
      OP_START, OP_LINK: begin
        emit = 1'b1;
        job_next.kind = (in_item.operation == OP_START) ? JOB_START : JOB_CLEAR;
        cnt_next = '0;
        exp_next = '0;
        drop_next = 1'b0;
        started_next = 1'b0;
      end
      OP_NOTIFY: begin
        if (!frag_started) begin
          drop_w = 1'b0;
          if (in_item.fragment_length == 11'd0) begin
            drop_w = 1'b1;
          end else if (sum > 18'(RX_BUFFER_BYTES)) begin
            cnt_w = '0;
            exp_next = '0;
            drop_w = 1'b1;
            emit = 1'b1;
            job_next.kind = JOB_STATUS;
            job_next.status = ST_OVERFLOW;
          end
        end
        if (!drop_w && cnt_w < CW'(RX_BUFFER_BYTES)) begin
          if (cnt_w == CW'(4)) c_len_lo = in_item.data_byte;
          if (cnt_w == CW'(5)) c_len_hi = in_item.data_byte;
          if (cnt_w == CW'(9)) c_cache_hi = in_item.data_byte;
          cnt_w = cnt_w + 1'b1;
        end
        cnt_next = cnt_w;
        drop_next = drop_w;
        started_next = 1'b1;
        if (in_item.fragment_end) begin
          started_next = 1'b0;
          drop_next = 1'b0;
          if (!drop_w) begin
            e = {1'b0, c_len_hi, c_len_lo} + 17'd2;
            if (exp_next == '0 && cnt_w >= CW'(6)) begin
              if (e > 17'(RX_BUFFER_BYTES)) begin
                cnt_next = '0;
                emit = 1'b1;
                job_next.kind = JOB_STATUS;
                job_next.status = ST_BADLEN;
              end else begin
                exp_next = e;
              end
            end
            if (!emit && exp_next != '0 && 17'(cnt_w) >= exp_next) begin
              emit = 1'b1;
              frame_len = exp_next;
              cnt_next = '0;
              exp_next = '0;
              if (frame_len < 17'd10) begin
                job_next.kind = JOB_STATUS;
                job_next.status = ST_SHORT;
              end else if (cap[0] == CMD_HANDSHAKE) begin
                job_next.kind = JOB_ACK_HS;
              end else if (cap[0] == CMD_CHUNK) begin
                job_next.kind = JOB_ACK_CHUNK;
              end else begin
                job_next.kind = JOB_STATUS;
                job_next.status = ST_UNKNOWN;
              end
              job_next.ack_status = cap[3];
              job_next.cache = {c_cache_hi, cap[4]};
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      rx_expected <= '0;
      frag_dropping <= 1'b0;
      frag_started <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_ready) job_valid <= 1'b0;
      if (take) begin
        rx_count <= cnt_next;
        rx_expected <= exp_next;
        frag_dropping <= drop_next;
        frag_started <= started_next;
        if (emit) job_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) job <= job_next;
    if (take && in_item.operation == OP_NOTIFY && !drop_w && cnt_next != rx_count) begin
      case (rx_count)
        CW'(1): cap[0] <= in_item.data_byte;
        CW'(4): cap[1] <= in_item.data_byte;
        CW'(5): cap[2] <= in_item.data_byte;
        CW'(6): cap[3] <= in_item.data_byte;
        CW'(8): cap[4] <= in_item.data_byte;
        CW'(9): cap[5] <= in_item.data_byte;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/cuae_back.sv -----
// ----------------------------------------------------------------------------
// cuae_back: transfer state and result emission
// Runs one job at a time and streams frame bytes, read requests and status.
// ----------------------------------------------------------------------------
module cuae_back #(
  parameter int MAX_FRAME_BYTES = 600
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        total,
  input  logic               job_valid,
  input  cuae_pkg::job_t     job,
  output logic               job_ready,
  output logic               out_valid,
  output cuae_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import cuae_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_QUEUE, S_HS, S_CHUNK, S_STATUS} state_t;

  state_t      state;
  job_t        cur;
  logic [15:0] chunk_size;
  logic [7:0]  seq_num;
  logic [32:0] bytes_acked;
  logic        awaiting_ack;
  logic [2:0]  retry_count;
  logic [9:0]  pending_data;
  logic [15:0] pending_frame;
  logic [3:0]  idx;
  logic [3:0]  status;
  logic [31:0] total_hold;

  logic        out_free;
  logic [32:0] remaining;
  logic [15:0] len;
  logic [16:0] flen;
  logic [32:0] acked_sum;

  assign out_free = !out_valid || !out_stall;
  assign job_ready = state == S_IDLE;
  assign remaining = {1'b0, total} - bytes_acked;
  assign len = (remaining < {17'd0, chunk_size}) ? remaining[15:0] : chunk_size;
  assign flen = {1'b0, len} + 17'd12;
  assign acked_sum = (bytes_acked > 33'h1FFFFFFFF - {23'd0, pending_data})
                     ? 33'h1FFFFFFFF : bytes_acked + {23'd0, pending_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      chunk_size <= '0;
      seq_num <= 8'd1;
      bytes_acked <= '0;
      awaiting_ack <= 1'b0;
      retry_count <= '0;
      pending_data <= '0;
      pending_frame <= '0;
      idx <= '0;
    end else begin
      if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_IDLE;
          idx <= '0;
          case (cur.kind)
            JOB_START, JOB_CLEAR: begin
              chunk_size <= '0;
              seq_num <= 8'd1;
              bytes_acked <= '0;
              awaiting_ack <= 1'b0;
              retry_count <= '0;
              pending_data <= '0;
              pending_frame <= '0;
              total_hold <= total;
              if (cur.kind == JOB_START) state <= S_HS;
            end
            JOB_STATUS: begin
              status <= cur.status;
              state <= S_STATUS;
            end
            JOB_ACK_HS: begin
              if (cur.ack_status != 8'd0) begin
                status <= ST_REJECTED;
                state <= S_STATUS;
              end else if (cur.cache <= 16'd12) begin
                status <= ST_CACHE;
                state <= S_STATUS;
              end else begin
                chunk_size <= cur.cache - 16'd12;
                seq_num <= 8'd1;
                bytes_acked <= '0;
                awaiting_ack <= 1'b0;
                state <= S_QUEUE;
              end
            end
            JOB_ACK_CHUNK: begin
              if (cur.ack_status == 8'd0) begin
                awaiting_ack <= 1'b0;
                bytes_acked <= acked_sum;
                if (acked_sum >= {1'b0, total}) begin
                  status <= ST_DONE;
                  state <= S_STATUS;
                end else begin
                  seq_num <= seq_num + 8'd1;
                  state <= S_QUEUE;
                end
              end else if (awaiting_ack && pending_frame != 16'd0) begin
                if (retry_count < 3'd4) retry_count <= retry_count + 3'd1;
                if (retry_count >= 3'd3) begin
                  status <= ST_RETRIES;
                  state <= S_STATUS;
                end else begin
                  state <= S_CHUNK;
                end
              end
            end
            default: ;
          endcase
        end
        S_QUEUE: begin
          state <= S_IDLE;
          idx <= '0;
          if (chunk_size != 16'd0) begin
            if (bytes_acked >= {1'b0, total}) begin
              status <= ST_DONE;
              state <= S_STATUS;
            end else if (flen > 17'(MAX_FRAME_BYTES)) begin
              status <= ST_BIG;
              state <= S_STATUS;
            end else begin
              pending_frame <= flen[15:0];
              pending_data <= len[9:0];
              awaiting_ack <= 1'b1;
              retry_count <= '0;
              state <= S_CHUNK;
            end
          end
        end
        S_HS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item <= '0;
            out_item.result_kind <= KIND_BYTE;
            case (idx)
              4'd12: out_item.frame_byte <= total_hold[7:0];
              4'd13: out_item.frame_byte <= total_hold[15:8];
              4'd14: out_item.frame_byte <= total_hold[23:16];
              4'd15: out_item.frame_byte <= total_hold[31:24];
              default: out_item.frame_byte <= header_byte(idx, CMD_HANDSHAKE, 16'd16, 8'd0);
            endcase
            out_item.run_end <= idx == 4'd15;
            idx <= idx + 4'd1;
            if (idx == 4'd15) state <= S_IDLE;
          end
        end
        S_CHUNK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item <= '0;
            if (idx == 4'd12) begin
              out_item.result_kind <= KIND_READ;
              out_item.payload_offset <= bytes_acked[31:0];
              out_item.payload_count <= pending_data;
              out_item.run_end <= 1'b1;
              state <= S_IDLE;
            end else begin
              out_item.result_kind <= KIND_BYTE;
              out_item.frame_byte <= header_byte(idx, CMD_CHUNK, pending_frame, seq_num);
            end
            idx <= idx + 4'd1;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item <= '0;
            out_item.result_kind <= KIND_STATUS;
            out_item.status_code <= status;
            out_item.run_end <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/chunked_upload_ack_engine.sv -----
// ----------------------------------------------------------------------------
// chunked_upload_ack_engine: stop-and-wait upload engine
// Reassembles ack frames from notification bytes and emits handshake,
// chunk headers with payload read descriptors, and status events.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | in_item_t
//   out     | output    | out_valid/stall  | out_item_t
//   cfg     | input     | cfg_valid/ready  | 32-bit total length
//
// A notify byte that completes nothing updates only the front part's state.
// Jobs pass a one-entry queue; the back part registers a job while idle and
// decides on it in a decide state, then sizes a chunk after a good ack. It
// emits one result per unstalled cycle (16 handshake bytes, 13 chunk results).
// Reset is synchronous; the front stalls input while its queue entry waits.
// ----------------------------------------------------------------------------
module chunked_upload_ack_engine #(
  parameter int RX_BUFFER_BYTES = 1024,
  parameter int MAX_FRAME_BYTES = 600
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  cuae_pkg::in_item_t  in_item,
  output logic                in_stall,
  output logic                out_valid,
  output cuae_pkg::out_item_t out_item,
  input  logic                out_stall,
  input  logic                cfg_valid,
  input  logic [31:0]         cfg_data,
  output logic                cfg_ready
);
  import cuae_pkg::*;

  logic        in_ready;
  logic        job_valid, job_ready;
  job_t        job;
  logic [31:0] payload_total_length;

  assign in_stall = !in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) payload_total_length <= '0;
    else if (cfg_valid) payload_total_length <= cfg_data;
  end

  cuae_front #(.RX_BUFFER_BYTES(RX_BUFFER_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_item, .in_ready,
    .job_valid, .job, .job_ready
  );

  cuae_back #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_back (
    .clk, .rst, .total(payload_total_length), .job_valid, .job, .job_ready,
    .out_valid, .out_item, .out_stall
  );

endmodule

// ----- tb/chunked_upload_ack_engine_test.sv -----
// ----------------------------------------------------------------------------
// chunked_upload_ack_engine_test: self-checking bench for the upload engine
// Drives notify, start and link-reset items through the stall handshake,
// keeps a cycle-free model of the ack decoder and chunk scheduler, and
// compares every result item field by field against it. Runs a directed
// table, then handshake/chunk-ack sessions with random fragmentation,
// malformed frames and noise, across several total-length settings.
// ----------------------------------------------------------------------------
module chunked_upload_ack_engine_test;
  import cuae_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LATENCY = 40;
  localparam int LIMIT = 1000000;
  localparam int RAND_ITEMS = 260;
  localparam int RXBUF = 1024;
  localparam int MAXFRAME = 600;
  localparam longint unsigned ACKED_MAX = 64'h1_FFFF_FFFF;

  localparam int ROW_NONE = 1;
  localparam int ROW_LAST = 2;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  in_item_t in_item;
  logic in_stall;
  logic out_valid;
  out_item_t out_item;
  logic out_stall = 1'b0;
  logic cfg_valid;
  logic [31:0] cfg_data;
  logic cfg_ready;

  chunked_upload_ack_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
    .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cfg_ready(cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine model state
  logic [31:0] total_bytes;
  int rx_cnt, rx_exp;
  logic [7:0] cap [6];
  bit frag_drop, frag_open;
  int chunk_sz;
  logic [7:0] seq_no;
  longint unsigned acked;
  bit awaiting;
  int retries;
  int pend_data, pend_frame;

  out_item_t run_q[$];
  out_item_t last_run[$];
  out_item_t expected_q[$];

  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_rand = 0;
  int n_results = 0;
  int n_cfg = 0;
  int burst_left = 0;
  bit counting = 0;

  function automatic void push_res(logic [1:0] kind, logic [7:0] b, logic [31:0] off,
                                   int cnt, logic [3:0] code);
    out_item_t r;
    r.result_kind = kind;
    r.frame_byte = b;
    r.payload_offset = off;
    r.payload_count = cnt[9:0];
    r.status_code = code;
    r.run_end = 1'b0;
    if (run_q.size() < 16) run_q.push_back(r);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    push_res(KIND_BYTE, b, 32'd0, 0, ST_DONE);
  endfunction

  function automatic void push_status(logic [3:0] code);
    push_res(KIND_STATUS, 8'd0, 32'd0, 0, code);
  endfunction

  function automatic void clear_all();
    chunk_sz = 0; seq_no = 8'd1; acked = 0; awaiting = 0; retries = 0;
    pend_data = 0; pend_frame = 0; rx_cnt = 0; rx_exp = 0;
    frag_drop = 0; frag_open = 0;
  endfunction

  function automatic void chunk_header(logic [7:0] cmd, int flen, logic [7:0] sq);
    push_byte(8'hAA); push_byte(cmd); push_byte(8'h00); push_byte(8'h5A);
    push_byte(flen[7:0]); push_byte(flen[15:8]); push_byte(sq); push_byte(8'h00);
    push_byte("T"); push_byte("F"); push_byte("1"); push_byte(8'h00);
  endfunction

  function automatic void send_pending();
    chunk_header(CMD_CHUNK, pend_frame, seq_no);
    push_res(KIND_READ, 8'd0, acked[31:0], pend_data, ST_DONE);
  endfunction

  function automatic void next_chunk();
    longint unsigned rem;
    int len;
    if (chunk_sz == 0) return;
    if (acked >= longint'(total_bytes)) begin
      push_status(ST_DONE);
      return;
    end
    rem = longint'(total_bytes) - acked;
    len = (rem < chunk_sz) ? int'(rem) : chunk_sz;
    if (12 + len > MAXFRAME) begin
      push_status(ST_BIG);
      return;
    end
    pend_frame = 12 + len;
    pend_data = len;
    awaiting = 1;
    retries = 0;
    send_pending();
  endfunction

  function automatic void decode_ack(int len);
    logic [7:0] cmd, st;
    int cache;
    if (len < 10) begin
      push_status(ST_SHORT);
      return;
    end
    cmd = cap[0];
    st = cap[3];
    if (cmd == CMD_HANDSHAKE) begin
      if (st != 0) begin
        push_status(ST_REJECTED);
        return;
      end
      cache = int'({cap[5], cap[4]});
      if (cache <= 12) begin
        push_status(ST_CACHE);
        return;
      end
      chunk_sz = cache - 12;
      seq_no = 8'd1;
      acked = 0;
      awaiting = 0;
      next_chunk();
    end else if (cmd == CMD_CHUNK) begin
      if (st == 0) begin
        awaiting = 0;
        acked += pend_data;
        if (acked > ACKED_MAX) acked = ACKED_MAX;
        if (acked >= longint'(total_bytes)) begin
          push_status(ST_DONE);
          return;
        end
        seq_no = seq_no + 8'd1;
        next_chunk();
      end else if (awaiting && pend_frame != 0) begin
        if (retries < 4) retries++;
        if (retries > 3) push_status(ST_RETRIES);
        else send_pending();
      end
    end else begin
      push_status(ST_UNKNOWN);
    end
  endfunction

  function automatic void take_byte(logic [7:0] b, int flen, bit last);
    int e;
    if (!frag_open) begin
      frag_open = 1;
      frag_drop = 0;
      if (flen == 0) frag_drop = 1;
      else if (rx_cnt + flen > RXBUF) begin
        rx_cnt = 0; rx_exp = 0; frag_drop = 1;
        push_status(ST_OVERFLOW);
      end
    end
    if (!frag_drop && rx_cnt < RXBUF) begin
      case (rx_cnt)
        1: cap[0] = b;
        4: cap[1] = b;
        5: cap[2] = b;
        6: cap[3] = b;
        8: cap[4] = b;
        9: cap[5] = b;
        default: ;
      endcase
      rx_cnt++;
    end
    if (!last) return;
    frag_open = 0;
    if (frag_drop) begin
      frag_drop = 0;
      return;
    end
    if (rx_exp == 0 && rx_cnt >= 6) begin
      e = {cap[2], cap[1]} + 2;
      if (e > RXBUF) begin
        rx_cnt = 0; rx_exp = 0;
        push_status(ST_BADLEN);
        return;
      end
      rx_exp = e;
    end
    if (rx_exp > 0 && rx_cnt >= rx_exp) begin
      decode_ack(rx_exp);
      rx_cnt = 0; rx_exp = 0;
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    run_q.delete();
    case (it.operation)
      OP_NOTIFY: take_byte(it.data_byte, it.fragment_length, it.fragment_end);
      OP_START: begin
        clear_all();
        chunk_header(CMD_HANDSHAKE, 16, 8'd0);
        push_byte(total_bytes[7:0]); push_byte(total_bytes[15:8]);
        push_byte(total_bytes[23:16]); push_byte(total_bytes[31:24]);
      end
      OP_LINK: clear_all();
      default: ;
    endcase
    if (run_q.size() > 0) run_q[run_q.size() - 1].run_end = 1'b1;
    last_run = run_q;
    foreach (run_q[i]) expected_q.push_back(run_q[i]);
  endfunction

  function automatic void report(string what, out_item_t e, out_item_t a);
    errors++;
    if (errors <= 10)
      $display("%s: exp kind=%0d byte=%02h off=%0d cnt=%0d st=%0d end=%0d", what,
               e.result_kind, e.frame_byte, e.payload_offset, e.payload_count,
               e.status_code, e.run_end,
               " / got kind=%0d byte=%02h off=%0d cnt=%0d st=%0d end=%0d",
               a.result_kind, a.frame_byte, a.payload_offset, a.payload_count,
               a.status_code, a.run_end);
  endfunction

  // result monitor, receiver stall pattern, run limit
  always @(posedge clk) begin
    out_item_t e;
    int mode;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      if (!rst && out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          e = '0;
          report("unexpected result", e, out_item);
        end else begin
          e = expected_q.pop_front();
          if (e !== out_item) report("result mismatch", e, out_item);
        end
      end
      mode = (cycles >> 7) % 4;
      if (rst) out_stall <= 1'b0;
      else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom % 4 == 0);
          2: out_stall <= ($urandom % 4 != 0);
          default: out_stall <= (cycles % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom % 5 == 0) ? 60 : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    burst_left--;
    n_items++;
    if (counting) n_rand++;
  endtask

  task automatic send_op(logic [1:0] op);
    in_item_t it;
    it = '0;
    it.operation = op;
    it.data_byte = 8'($urandom);
    it.fragment_length = 11'($urandom);
    it.fragment_end = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] b, int flen, bit last);
    in_item_t it;
    it.operation = OP_NOTIFY;
    it.data_byte = b;
    it.fragment_length = flen[10:0];
    it.fragment_end = last;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    total_bytes = v;
    n_cfg++;
  endtask

  // split a frame into fragments of random size
  task automatic send_frame(logic [7:0] fr[$]);
    int idx, n, fl;
    idx = 0;
    while (idx < fr.size()) begin
      n = ($urandom % 4 == 0) ? fr.size() - idx
                              : $urandom_range(1, (fr.size() - idx < 12) ? fr.size() - idx : 12);
      fl = ($urandom % 16 == 0) ? $urandom_range(0, 2047) : n;
      for (int i = 0; i < n; i++) send_byte(fr[idx + i], fl, i == n - 1);
      idx += n;
    end
  endtask

  task automatic send_ack(logic [7:0] cmd, logic [7:0] st, logic [15:0] cache, int len,
                          int decl);
    logic [7:0] fr[$];
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
    fr[1] = cmd;
    if (len > 5) begin
      fr[4] = decl[7:0];
      fr[5] = decl[15:8];
    end
    if (len > 6) fr[6] = st;
    if (len > 9) begin
      fr[8] = cache[7:0];
      fr[9] = cache[15:8];
    end
    send_frame(fr);
  endtask

  task automatic session();
    int r, len, n;
    logic [15:0] cache;
    logic [7:0] st;
    send_op(OP_START);
    r = $urandom % 10;
    st = 8'd0;
    if (r == 0) cache = 16'($urandom_range(0, 12));
    else if (r == 1) cache = 16'($urandom_range(601, 1200));
    else if (r == 2) cache = 16'hFFFF;
    else cache = 16'($urandom_range(13, 120));
    if (r == 3) st = 8'($urandom_range(1, 255));
    len = 10 + $urandom % 5;
    send_ack(CMD_HANDSHAKE, st, cache, len, len - 2);
    n = $urandom_range(1, 4);
    repeat (n) begin
      st = ($urandom % 3 == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      len = 10 + $urandom % 5;
      send_ack(CMD_CHUNK, st, 16'($urandom), len, len - 2);
    end
  endtask

  task automatic broken_frame();
    int r, len;
    r = $urandom % 3;
    if (r == 0) begin
      len = $urandom_range(6, 9);
      send_ack(CMD_CHUNK, 8'd0, 16'd0, len, len - 2);
    end else if (r == 1) begin
      send_ack(CMD_HANDSHAKE, 8'd0, 16'd0, 6, $urandom_range(1023, 65535));
    end else begin
      len = 10 + $urandom % 5;
      send_ack(8'($urandom_range(19, 255)), 8'd0, 16'($urandom), len, len - 2);
    end
  endtask

  task automatic noise();
    in_item_t it;
    repeat ($urandom_range(1, 6)) begin
      it.operation = 2'($urandom);
      it.data_byte = 8'($urandom);
      it.fragment_length = 11'($urandom);
      it.fragment_end = ($urandom % 3 == 0);
      send_item(it);
    end
    if ($urandom % 2) send_op(OP_LINK);
  endtask

  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
    logic [10:0] fl;
    logic fe;
    int chk;
    logic [1:0] kind;
    logic [7:0] fbyte;
    logic [3:0] code;
  } row_t;

  row_t rows[$];

  function automatic void add_row(logic [1:0] op, logic [7:0] b, logic [10:0] fl, logic fe,
                                  int chk, logic [1:0] kind, logic [7:0] fbyte,
                                  logic [3:0] code);
    row_t r;
    r.op = op; r.b = b; r.fl = fl; r.fe = fe;
    r.chk = chk; r.kind = kind; r.fbyte = fbyte; r.code = code;
    rows.push_back(r);
  endfunction

  logic [31:0] phase_len [6];

  initial begin
    in_item_t it;
    out_item_t got;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = 32'd0;
    total_bytes = 32'd0;
    foreach (cap[i]) cap[i] = 8'd0;
    clear_all();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_total(32'h1234_5678);

    add_row(OP_START, 8'h00, 11'd0, 1'b0, ROW_LAST, KIND_BYTE, 8'h12, ST_DONE);
    add_row(OP_UNUSED, 8'hFF, 11'h7FF, 1'b1, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_LINK, 8'h00, 11'd0, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h55, 11'd0, 1'b1, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h00, 11'h7FF, 1'b0, ROW_LAST, KIND_STATUS, 8'h00, ST_OVERFLOW);
    add_row(OP_NOTIFY, 8'hFF, 11'd5, 1'b1, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h00, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, CMD_HANDSHAKE, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h00, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h00, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h04, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'h00, 11'd6, 1'b1, ROW_LAST, KIND_STATUS, 8'h00, ST_SHORT);
    add_row(OP_NOTIFY, 8'hFF, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, CMD_CHUNK, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'hFF, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'hFF, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'hFF, 11'd6, 1'b0, ROW_NONE, KIND_BYTE, 8'h00, ST_DONE);
    add_row(OP_NOTIFY, 8'hFF, 11'd6, 1'b1, ROW_LAST, KIND_STATUS, 8'h00, ST_BADLEN);
    add_row(OP_START, 8'h00, 11'd0, 1'b0, ROW_LAST, KIND_BYTE, 8'h12, ST_DONE);

    foreach (rows[i]) begin
      it.operation = rows[i].op;
      it.data_byte = rows[i].b;
      it.fragment_length = rows[i].fl;
      it.fragment_end = rows[i].fe;
      send_item(it);
      if (rows[i].chk == ROW_NONE && last_run.size() != 0) begin
        got = last_run[0];
        report("table row expects no result", '0, got);
      end else if (rows[i].chk == ROW_LAST) begin
        got = '0;
        if (last_run.size() != 0) got = last_run[last_run.size() - 1];
        if (got.result_kind !== rows[i].kind || got.frame_byte !== rows[i].fbyte ||
            got.status_code !== rows[i].code) begin
          it = '0;
          report("table row final result", '{result_kind: rows[i].kind,
                 frame_byte: rows[i].fbyte, payload_offset: 32'd0, payload_count: 10'd0,
                 status_code: rows[i].code, run_end: 1'b1}, got);
        end
      end
    end

    phase_len[0] = 32'd0;
    phase_len[1] = 32'd1;
    phase_len[2] = 32'd500;
    phase_len[3] = 32'hFFFF_FFFF;
    phase_len[4] = $urandom_range(2, 3000);
    phase_len[5] = 32'd40;
    counting = 1;
    foreach (phase_len[p]) begin
      write_total(phase_len[p]);
      while (n_rand < (p + 1) * RAND_ITEMS / 6) begin
        case ($urandom % 8)
          0: noise();
          1: broken_frame();
          default: session();
        endcase
        if (p == 3 && n_rand > (7 * RAND_ITEMS) / 12 && n_rand < (8 * RAND_ITEMS) / 12)
          drain();
      end
    end

    drain();
    $display("covered %0d items (%0d random), %0d results, %0d length settings",
             n_items, n_rand, n_results, n_cfg);
    $display("sessions, ack decode errors, retries, overflow and noise; %0d mismatches",
             errors);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
